// File: hdl/tiap_pkg.sv
// Package for the time-indexed affine policy block: sizes, codes, item types and helpers.
`timescale 1ns / 1ps
package tiap_pkg;

    // Storage sizes.
    localparam int MAX_HORIZON    = 64;
    localparam int MAX_STATE_DIM  = 16;
    localparam int MAX_ACTION_DIM = 8;

    // Index widths.
    localparam int T_W  = $clog2(MAX_HORIZON);
    localparam int R_W  = $clog2(MAX_ACTION_DIM);
    localparam int C_W  = $clog2(MAX_STATE_DIM);
    localparam int SD_W = $clog2(MAX_STATE_DIM + 1);
    localparam int AD_W = $clog2(MAX_ACTION_DIM + 1);
    localparam int J_W  = (SD_W > AD_W) ? SD_W : AD_W;

    // Memory address widths.
    localparam int GA_W  = T_W + R_W + C_W;
    localparam int OA_W  = T_W + R_W;
    localparam int NA_W  = T_W + R_W + R_W;
    localparam int CLR_W = (GA_W > NA_W) ? GA_W : NA_W;

    // Configuration register widths.
    localparam int HZ_W = 7;
    localparam int SDR_W = 5;
    localparam int ADR_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_DIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_DIM = 2'd2;

    // Action codes of an input item.
    localparam logic [2:0] ACT_GAIN    = 3'd0;
    localparam logic [2:0] ACT_OFFSET  = 3'd1;
    localparam logic [2:0] ACT_NSCALE  = 3'd2;
    localparam logic [2:0] ACT_STATE   = 3'd3;
    localparam logic [2:0] ACT_NOISE   = 3'd4;
    localparam logic [2:0] ACT_COMPUTE = 3'd5;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    // Queue depth between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = $clog2(Q_DEPTH);

    // Input item.
    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         timestep;
        logic [2:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic               use_noise;
    } cmd_t;

    // Result item.
    typedef struct packed {
        logic [2:0]         component;
        logic signed [31:0] control;
        logic               last;
        logic               status;
    } res_t;

    // Classified work for the back end.
    typedef enum logic [2:0] {
        K_GAIN,
        K_OFFSET,
        K_NSCALE,
        K_STATE,
        K_NOISE,
        K_COMPUTE,
        K_ERROR
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [T_W-1:0]     t;
        logic [R_W-1:0]     r;
        logic [C_W-1:0]     c;
        logic signed [31:0] value;
        logic               noisy;
        logic [SD_W-1:0]    sd;
        logic [AD_W-1:0]    ad;
    } work_t;

    // Back end status seen by the front.
    typedef struct packed {
        logic clearing;
    } back_status_t;

    // Signed 64-bit add that saturates at the limits.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
        begin
            s = a[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    // Round Q32.32 to Q16.16 and saturate to 32 bits.
    function automatic logic signed [31:0] round_sat32(input logic signed [63:0] acc);
        logic signed [63:0] r;
        logic [31:0]        q;
        r = sat_add64(acc, 64'sd32768);
        if ((&r[63:47]) || !(|r[63:47]))
        begin
            q = r[47:16];
        end
        else
        begin
            q = r[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return q;
    endfunction

endpackage

// File: hdl/tiap_front.sv
// Front end: configuration registers, item decode, range checks and clamped dimensions.
`timescale 1ns / 1ps
module tiap_front import tiap_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    input  back_status_t          bstat,
    output logic                  q_push,
    output work_t                 q_data
);

    logic [HZ_W-1:0]  horizon_reg;
    logic [SDR_W-1:0] state_dim_reg;
    logic [ADR_W-1:0] action_dim_reg;
    logic [HZ_W-1:0]  hz;
    logic             useful;
    kind_t            kind;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg    <= HZ_W'(64);
            state_dim_reg  <= SDR_W'(16);
            action_dim_reg <= ADR_W'(8);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HORIZON:    horizon_reg    <= cfg_data[HZ_W-1:0];
                CFG_STATE_DIM:  state_dim_reg  <= cfg_data[SDR_W-1:0];
                CFG_ACTION_DIM: action_dim_reg <= cfg_data[ADR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Timesteps in use, limited to storage.
    assign hz = (horizon_reg < HZ_W'(MAX_HORIZON)) ? horizon_reg : HZ_W'(MAX_HORIZON);

    // Classify the item and drop those that change nothing.
    always_comb
    begin
        kind   = K_ERROR;
        useful = 1'b0;
        unique case (cmd.action)
            ACT_GAIN:
            begin
                kind   = K_GAIN;
                useful = (32'(cmd.timestep) < 32'(MAX_HORIZON))
                      && (32'(cmd.row) < 32'(MAX_ACTION_DIM))
                      && (32'(cmd.col) < 32'(MAX_STATE_DIM));
            end
            ACT_OFFSET:
            begin
                kind   = K_OFFSET;
                useful = (32'(cmd.timestep) < 32'(MAX_HORIZON))
                      && (32'(cmd.row) < 32'(MAX_ACTION_DIM));
            end
            ACT_NSCALE:
            begin
                kind   = K_NSCALE;
                useful = (32'(cmd.timestep) < 32'(MAX_HORIZON))
                      && (32'(cmd.row) < 32'(MAX_ACTION_DIM))
                      && (32'(cmd.col) < 32'(MAX_ACTION_DIM));
            end
            ACT_STATE:
            begin
                kind   = K_STATE;
                useful = 32'(cmd.col) < 32'(MAX_STATE_DIM);
            end
            ACT_NOISE:
            begin
                kind   = K_NOISE;
                useful = 32'(cmd.row) < 32'(MAX_ACTION_DIM);
            end
            ACT_COMPUTE:
            begin
                kind   = (HZ_W'(cmd.timestep) >= hz) ? K_ERROR : K_COMPUTE;
                useful = 1'b1;
            end
            default:
            begin
                kind   = K_ERROR;
                useful = 1'b0;
            end
        endcase
    end

    // Build the queue entry with the dimensions already clamped.
    always_comb
    begin
        q_data.kind  = kind;
        q_data.t     = cmd.timestep[T_W-1:0];
        q_data.r     = cmd.row[R_W-1:0];
        q_data.c     = cmd.col[C_W-1:0];
        q_data.value = cmd.value;
        q_data.noisy = cmd.use_noise;
        q_data.sd    = (32'(state_dim_reg) < MAX_STATE_DIM)
                     ? SD_W'(state_dim_reg) : SD_W'(MAX_STATE_DIM);
        if (action_dim_reg == '0)
        begin
            q_data.ad = AD_W'(1);
        end
        else if (32'(action_dim_reg) < MAX_ACTION_DIM)
        begin
            q_data.ad = AD_W'(action_dim_reg);
        end
        else
        begin
            q_data.ad = AD_W'(MAX_ACTION_DIM);
        end
    end

    assign cmd_ready = !q_full && !bstat.clearing;
    assign q_push    = cmd_valid && cmd_ready && useful;

endmodule

// File: hdl/tiap_queue.sv
// Short queue of classified work between the front and back ends.
`timescale 1ns / 1ps
module tiap_queue import tiap_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output work_t head,
    output logic  full,
    output logic  empty
);

    work_t           slot_reg [Q_DEPTH];
    logic [Q_PW-1:0] wr_ptr_reg;
    logic [Q_PW-1:0] rd_ptr_reg;
    logic [Q_PW:0]   count_reg;

    assign full  = (count_reg == (Q_PW+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/tiap_back.sv
// Back end: table memories, vectors, clearing pass and the multiply-accumulate sequencer.
`timescale 1ns / 1ps
module tiap_back import tiap_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  work_t        q_head,
    output logic         q_pop,
    output back_status_t bstat,
    output logic         res_valid,
    input  logic         res_ready,
    output res_t         res
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_GAIN  = 7'b0000100,
        S_OFFS  = 7'b0001000,
        S_NOIS  = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        SEL_GAIN,
        SEL_OFFS,
        SEL_NOIS
    } sel_t;

    state_t state_reg, state_next;

    // Memories.
    logic signed [31:0] gain_mem   [2**GA_W];
    logic signed [31:0] offset_mem [2**OA_W];
    logic signed [31:0] nscale_mem [2**NA_W];
    logic signed [31:0] gain_rd_reg, offset_rd_reg, nscale_rd_reg;

    logic signed [31:0] state_vec_reg [MAX_STATE_DIM];
    logic signed [31:0] noise_vec_reg [MAX_ACTION_DIM];

    logic [CLR_W-1:0]   clr_reg;
    work_t              job_reg;
    logic [R_W-1:0]     comp_reg, comp_next;
    logic [J_W-1:0]     j_reg, j_next;
    logic               err_reg, err_next;

    // Term pipeline.
    logic               v1_reg, end1_reg, v2_reg, end2_reg;
    sel_t               sel1_reg;
    logic signed [31:0] b1_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic               done_reg;

    logic               issue, issue_end;
    sel_t               issue_sel;
    logic signed [31:0] issue_b;
    logic signed [31:0] a1;
    logic               out_free;
    logic               last_comp;
    logic               start_job, emit_now;

    logic               gain_we, offset_we, nscale_we;
    logic [GA_W-1:0]    gain_wa, gain_ra;
    logic [OA_W-1:0]    offset_wa, offset_ra;
    logic [NA_W-1:0]    nscale_wa, nscale_ra;
    logic signed [31:0] gain_wd, offset_wd, nscale_wd;
    logic               pop_write;

    res_t res_reg;
    logic res_valid_reg;

    assign bstat.clearing = (state_reg == S_CLEAR);
    assign out_free       = !res_valid_reg || res_ready;
    assign last_comp      = ({1'b0, comp_reg} == (job_reg.ad - AD_W'(1)));
    assign q_pop          = (state_reg == S_IDLE) && !q_empty;
    assign pop_write      = q_pop;
    assign start_job      = q_pop && (q_head.kind == K_COMPUTE);
    assign emit_now       = (state_reg == S_EMIT) && out_free;

    // Memory write ports: clearing pass or table writes.
    always_comb
    begin
        gain_we   = 1'b0;
        offset_we = 1'b0;
        nscale_we = 1'b0;
        gain_wa   = {q_head.t, q_head.r, q_head.c};
        offset_wa = {q_head.t, q_head.r};
        nscale_wa = {q_head.t, q_head.r, q_head.c[R_W-1:0]};
        gain_wd   = q_head.value;
        offset_wd = q_head.value;
        nscale_wd = q_head.value;
        if (state_reg == S_CLEAR)
        begin
            gain_we   = 1'b1;
            offset_we = 1'b1;
            nscale_we = 1'b1;
            gain_wa   = clr_reg[GA_W-1:0];
            offset_wa = clr_reg[OA_W-1:0];
            nscale_wa = clr_reg[NA_W-1:0];
            gain_wd   = '0;
            offset_wd = '0;
            nscale_wd = (clr_reg[2*R_W-1:R_W] == clr_reg[R_W-1:0]) ? ONE_Q16 : '0;
        end
        else if (pop_write)
        begin
            gain_we   = (q_head.kind == K_GAIN);
            offset_we = (q_head.kind == K_OFFSET);
            nscale_we = (q_head.kind == K_NSCALE);
        end
    end

    // Read addresses of the term being issued; L is read transposed.
    assign gain_ra   = {job_reg.t, comp_reg, j_reg[C_W-1:0]};
    assign offset_ra = {job_reg.t, comp_reg};
    assign nscale_ra = {job_reg.t, j_reg[R_W-1:0], comp_reg};

    always_ff @(posedge clk)
    begin
        if (gain_we)
        begin
            gain_mem[gain_wa] <= gain_wd;
        end
        gain_rd_reg <= gain_mem[gain_ra];
    end

    always_ff @(posedge clk)
    begin
        if (offset_we)
        begin
            offset_mem[offset_wa] <= offset_wd;
        end
        offset_rd_reg <= offset_mem[offset_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nscale_we)
        begin
            nscale_mem[nscale_wa] <= nscale_wd;
        end
        nscale_rd_reg <= nscale_mem[nscale_ra];
    end

    // State and noise vectors.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_STATE_DIM; k++)
            begin
                state_vec_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_ACTION_DIM; k++)
            begin
                noise_vec_reg[k] <= '0;
            end
        end
        else if (pop_write)
        begin
            if (q_head.kind == K_STATE)
            begin
                state_vec_reg[q_head.c] <= q_head.value;
            end
            if (q_head.kind == K_NOISE)
            begin
                noise_vec_reg[q_head.r] <= q_head.value;
            end
        end
    end

    // Sequencer: outside wait and emit, one term issued per cycle: gain terms, offset, then noise terms if noisy.
    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        j_next     = j_reg;
        err_next   = err_reg;
        issue      = 1'b0;
        issue_end  = 1'b0;
        issue_sel  = SEL_GAIN;
        issue_b    = state_vec_reg[j_reg[C_W-1:0]];
        unique case (state_reg)
            S_CLEAR:
            begin
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_pop)
                begin
                    comp_next = '0;
                    j_next    = '0;
                    if (q_head.kind == K_COMPUTE)
                    begin
                        err_next   = 1'b0;
                        state_next = (q_head.sd != '0) ? S_GAIN : S_OFFS;
                    end
                    else if (q_head.kind == K_ERROR)
                    begin
                        err_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_GAIN:
            begin
                issue     = 1'b1;
                issue_sel = SEL_GAIN;
                issue_b   = state_vec_reg[j_reg[C_W-1:0]];
                if (j_reg == J_W'(job_reg.sd - SD_W'(1)))
                begin
                    j_next     = '0;
                    state_next = S_OFFS;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_OFFS:
            begin
                issue     = 1'b1;
                issue_sel = SEL_OFFS;
                issue_b   = ONE_Q16;
                j_next    = '0;
                if (job_reg.noisy)
                begin
                    state_next = S_NOIS;
                end
                else
                begin
                    issue_end  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_NOIS:
            begin
                issue     = 1'b1;
                issue_sel = SEL_NOIS;
                issue_b   = noise_vec_reg[j_reg[R_W-1:0]];
                if (j_reg == J_W'(job_reg.ad - AD_W'(1)))
                begin
                    issue_end  = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (done_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (err_reg || last_comp)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        j_next     = '0;
                        state_next = (job_reg.sd != '0) ? S_GAIN : S_OFFS;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            comp_reg  <= '0;
            j_reg     <= '0;
            err_reg   <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            end1_reg  <= 1'b0;
            end2_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            j_reg     <= j_next;
            err_reg   <= err_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            v1_reg   <= issue;
            end1_reg <= issue && issue_end;
            v2_reg   <= v1_reg;
            end2_reg <= v1_reg && end1_reg;
            if (start_job || emit_now)
            begin
                done_reg <= 1'b0;
            end
            else if (v2_reg && end2_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Operand selection after the memory read.
    always_comb
    begin
        case (sel1_reg)
            SEL_GAIN: a1 = gain_rd_reg;
            SEL_OFFS: a1 = offset_rd_reg;
            default:  a1 = nscale_rd_reg;
        endcase
    end

    // Datapath: operand register, product register, saturating accumulator.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_head;
        end
        sel1_reg <= issue_sel;
        b1_reg   <= issue_b;
        prod_reg <= 64'(a1) * 64'(b1_reg);
        if (start_job || emit_now)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= sat_add64(acc_reg, prod_reg);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit_now)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            if (err_reg)
            begin
                res_reg.component <= '0;
                res_reg.control   <= '0;
                res_reg.last      <= 1'b1;
                res_reg.status    <= 1'b1;
            end
            else
            begin
                res_reg.component <= 3'(comp_reg);
                res_reg.control   <= round_sat32(acc_reg);
                res_reg.last      <= last_comp;
                res_reg.status    <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hdl/time_indexed_affine_policy.sv
// Top level of the time-indexed affine policy block.
//
// Items enter on cmd (valid/ready). Table, state and noise loads are applied
// in the back end as they leave the queue; a compute item for timestep t emits
// one result per control component on res (valid/ready), the final one with
// last set. A compute whose timestep is not below the horizon gives one result
// with status set. Each component issues sd + 1 (+ ad with noise) terms to the
// shared 32x32 multiplier, then drains the read, product and accumulate stages
// and loads the output register.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken; the
// user must make them only while the block is idle, which the block itself
// does not enforce.
// After reset the back end sweeps the tables, one entry a cycle, over 8192
// addresses (gain and offset to zero, noise scaling to identity); cmd_ready
// stays low during the sweep. A short queue parts the front from the back,
// so up to four items are taken while the back computes. When the receiver
// stalls, the result waits in the output register and the sequencer holds.
`timescale 1ns / 1ps
module time_indexed_affine_policy import tiap_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic         q_push, q_pop, q_full, q_empty;
    work_t        q_in, q_head;
    back_status_t bstat;

    tiap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .bstat     (bstat),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    tiap_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tiap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .bstat     (bstat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// File: hdl/tiap_checker.sv
// Port-level checker for the time-indexed affine policy block, bound to the top level.
`timescale 1ns / 1ps
module tiap_checker import tiap_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // An error result is a lone item with zero payload.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status) |-> (res.last && (res.component == '0) && (res.control == '0)))
        else $error("error result has wrong shape");

    // The table sweep holds off new items right after reset.
    a_sweep: assert property (@(posedge clk)
        $rose(rst_n) |-> !cmd_ready)
        else $error("item taken during table sweep");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("stalled result changed");

endmodule

bind time_indexed_affine_policy tiap_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// File: tb/tb_time_indexed_affine_policy.sv
// Self-checking testbench for the time-indexed affine policy block.
`timescale 1ns / 1ps
module tb_time_indexed_affine_policy;
    import tiap_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    cmd_t                  cmd = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_t                  res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    time_indexed_affine_policy dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block's tables, vectors and registers.
    logic signed [31:0] gain_mem [0:8191];
    logic signed [31:0] offset_mem [0:511];
    logic signed [31:0] nscale_mem [0:4095];
    logic signed [31:0] state_vec [0:15];
    logic signed [31:0] noise_vec [0:7];
    int                 horizon_reg = 64;
    int                 state_dim_reg = 16;
    int                 action_dim_reg = 8;

    cmd_t pending_cmds[$];
    res_t want_res[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   cmd_took = 1'b0;
    bit   hold_go = 1'b0;
    bit   hold_off = 1'b0;
    int   quiet_cycles = 0;

    // Clock with a 10 ns period.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Signed 64-bit add clamped at the limits.
    function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

    // One control component: gain row times state, offset, optional scaled noise.
    function automatic logic signed [31:0] control_value(input int t, input int i,
                                                         input int sd, input int ad,
                                                         input bit noisy);
        logic signed [63:0] acc;
        logic signed [63:0] a;
        logic signed [63:0] b;
        acc = 0;
        for (int j = 0; j < sd; j++)
        begin
            a = gain_mem[(t * 8 + i) * 16 + j];
            b = state_vec[j];
            acc = clamp_add(acc, a * b);
        end
        a = offset_mem[t * 8 + i];
        acc = clamp_add(acc, a <<< 16);
        if (noisy)
        begin
            for (int j = 0; j < ad; j++)
            begin
                a = nscale_mem[(t * 8 + j) * 8 + i];
                b = noise_vec[j];
                acc = clamp_add(acc, a * b);
            end
        end
        acc = clamp_add(acc, 64'sd32768);
        acc = acc >>> 16;
        if (acc > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (acc < -64'sd2147483648)
            return 32'sh8000_0000;
        return acc[31:0];
    endfunction

    // Applies one accepted item to the mirror and queues the results it causes.
    task automatic predict_item(input cmd_t c);
        int   hz;
        int   sd;
        int   ad;
        res_t r;
        case (c.action)
            ACT_GAIN:    gain_mem[{c.timestep, c.row, c.col}] = c.value;
            ACT_OFFSET:  offset_mem[{c.timestep, c.row}] = c.value;
            ACT_NSCALE:
            begin
                if (c.col < MAX_ACTION_DIM)
                    nscale_mem[{c.timestep, c.row, c.col[2:0]}] = c.value;
            end
            ACT_STATE:   state_vec[c.col] = c.value;
            ACT_NOISE:   noise_vec[c.row] = c.value;
            ACT_COMPUTE:
            begin
                hz = (horizon_reg < MAX_HORIZON) ? horizon_reg : MAX_HORIZON;
                if (c.timestep >= hz)
                begin
                    r.component = '0;
                    r.control = '0;
                    r.last = 1'b1;
                    r.status = 1'b1;
                    want_res.push_back(r);
                end
                else
                begin
                    sd = (state_dim_reg < MAX_STATE_DIM) ? state_dim_reg : MAX_STATE_DIM;
                    ad = (action_dim_reg < MAX_ACTION_DIM) ? action_dim_reg : MAX_ACTION_DIM;
                    if (ad == 0)
                        ad = 1;
                    for (int i = 0; i < ad; i++)
                    begin
                        r.component = i[2:0];
                        r.control = control_value(c.timestep, i, sd, ad, c.use_noise);
                        r.last = (i + 1 == ad);
                        r.status = 1'b0;
                        want_res.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic cmd_t make_cmd(input logic [2:0] act, input int t, input int r,
                                      input int c, input logic [31:0] v, input bit n);
        cmd_t x;
        x.action = act;
        x.timestep = t[5:0];
        x.row = r[2:0];
        x.col = c[3:0];
        x.value = v;
        x.use_noise = n;
        return x;
    endfunction

    // Random item, mostly loads and computes aimed inside the horizon in use.
    function automatic cmd_t random_cmd();
        cmd_t x;
        int   pick;
        int   hz;
        pick = $urandom_range(99);
        if (pick < 18)
            x.action = ACT_GAIN;
        else if (pick < 30)
            x.action = ACT_OFFSET;
        else if (pick < 40)
            x.action = ACT_NSCALE;
        else if (pick < 58)
            x.action = ACT_STATE;
        else if (pick < 68)
            x.action = ACT_NOISE;
        else if (pick < 95)
            x.action = ACT_COMPUTE;
        else
            x.action = 3'($urandom_range(6, 7));
        hz = (horizon_reg < MAX_HORIZON) ? horizon_reg : MAX_HORIZON;
        if (hz > 0 && $urandom_range(9) < 8)
            x.timestep = 6'($urandom_range(hz - 1));
        else
            x.timestep = 6'($urandom_range(63));
        x.row = 3'($urandom_range(7));
        if (x.action == ACT_NSCALE && $urandom_range(99) < 85)
            x.col = 4'($urandom_range(7));
        else
            x.col = 4'($urandom_range(15));
        if ($urandom_range(1))
            x.value = $urandom;
        else
            x.value = $urandom_range(262143) - 131072;
        x.use_noise = $urandom_range(1);
        return x;
    endfunction

    // Sender: offers queued items at the falling edge, idling at random.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (!cmd_valid || cmd_took)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random, or fully during a long hold-off.
    always @(negedge clk)
    begin
        res_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off while the sender keeps offering items.
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    // Monitor: predicts on accepted items, checks accepted results, watches for hangs.
    always @(posedge clk)
    begin
        cmd_took = cmd_valid && cmd_ready;
        if (cmd_took)
            predict_item(cmd);
        if (res_valid && res_ready)
        begin
            if (want_res.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: comp %0d ctrl %0d last %0b status %0b",
                             res.component, res.control, res.last, res.status);
            end
            else if (res !== want_res[0])
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp comp %0d ctrl %0d last %0b status %0b",
                              " / got comp %0d ctrl %0d last %0b status %0b"},
                             want_res[0].component, want_res[0].control, want_res[0].last,
                             want_res[0].status, res.component, res.control, res.last,
                             res.status);
                void'(want_res.pop_front());
            end
            else
            begin
                void'(want_res.pop_front());
            end
        end
        if (cmd_took || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[time_indexed_affine_policy] ERROR");
            $finish;
        end
    end

    // Register write, then update of the mirror once it is taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_HORIZON:    horizon_reg = data & 8'h7F;
            CFG_STATE_DIM:  state_dim_reg = data & 8'h1F;
            CFG_ACTION_DIM: action_dim_reg = data & 8'h0F;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Waits until every item is taken and every result has come, then lets the back settle.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() > 0 || cmd_valid || want_res.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_random(input int count);
        for (int k = 0; k < count; k++)
            pending_cmds.push_back(random_cmd());
    endtask

    // Stimulus in phases with different settings and idling.
    initial
    begin
        for (int k = 0; k < 8192; k++)
            gain_mem[k] = '0;
        for (int k = 0; k < 512; k++)
            offset_mem[k] = '0;
        for (int k = 0; k < 4096; k++)
            nscale_mem[k] = ((k / 8) % 8 == k % 8) ? ONE_Q16 : '0;
        for (int k = 0; k < 16; k++)
            state_vec[k] = '0;
        for (int k = 0; k < 8; k++)
            noise_vec[k] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes, saturation, ignored writes and unused codes at reset settings.
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 0, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(ACT_GAIN, 0, 0, 0, 32'h7FFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(ACT_GAIN, 63, 7, 15, 32'h8000_0000, 1));
        pending_cmds.push_back(make_cmd(ACT_OFFSET, 0, 7, 0, 32'h7FFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(ACT_STATE, 0, 0, 0, 32'h7FFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(ACT_STATE, 0, 0, 15, 32'h8000_0000, 0));
        pending_cmds.push_back(make_cmd(ACT_NOISE, 0, 0, 0, 32'h8000_0000, 0));
        pending_cmds.push_back(make_cmd(ACT_NOISE, 0, 7, 0, 32'h7FFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(ACT_NSCALE, 0, 7, 0, 32'h8000_0000, 0));
        pending_cmds.push_back(make_cmd(ACT_NSCALE, 0, 3, 12, 32'h1234_5678, 0));
        pending_cmds.push_back(make_cmd(3'd6, 0, 0, 0, 32'h5555_5555, 0));
        pending_cmds.push_back(make_cmd(3'd7, 63, 7, 15, 32'hFFFF_FFFF, 1));
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 0, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 0, 7, 15, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 63, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(ACT_GAIN, 5, 2, 3, 32'h0001_8000, 0));
        pending_cmds.push_back(make_cmd(ACT_STATE, 0, 0, 3, 32'h0002_0000, 0));
        pending_cmds.push_back(make_cmd(ACT_OFFSET, 5, 2, 0, 32'hFFFF_8000, 0));
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 5, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 5, 0, 0, 0, 1));
        add_random(40);
        drain();

        // Mid-size settings, sender idling; timestep past the horizon gives an error.
        write_reg(CFG_HORIZON, 8'd20);
        write_reg(CFG_STATE_DIM, 8'd4);
        write_reg(CFG_ACTION_DIM, 8'd3);
        send_idle_pct = 52;
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 63, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 20, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_COMPUTE, 19, 0, 0, 0, 1));
        add_random(60);
        drain();

        // Smallest sizes in range, receiver stalling.
        write_reg(CFG_HORIZON, 8'd1);
        write_reg(CFG_STATE_DIM, 8'd1);
        write_reg(CFG_ACTION_DIM, 8'd1);
        send_idle_pct = 0;
        recv_stall_pct = 52;
        add_random(50);
        drain();

        // Zero settings and the index past the register list.
        write_reg(CFG_HORIZON, 8'd0);
        write_reg(CFG_STATE_DIM, 8'd0);
        write_reg(CFG_ACTION_DIM, 8'd0);
        write_reg(2'd3, 8'hFF);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        add_random(20);
        drain();

        // Zero state dimension with a live horizon.
        write_reg(CFG_HORIZON, 8'd8);
        add_random(20);
        drain();

        // Oversized settings, clamped; long receiver hold-off fills the block.
        write_reg(CFG_HORIZON, 8'hFF);
        write_reg(CFG_STATE_DIM, 8'hFF);
        write_reg(CFG_ACTION_DIM, 8'hFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 1'b1;
        add_random(30);
        drain();
        send_idle_pct = 36;
        recv_stall_pct = 36;
        add_random(30);
        drain();

        if (errors == 0)
            $display("[time_indexed_affine_policy] OK");
        else
            $display("[time_indexed_affine_policy] ERROR");
        $finish;
    end

endmodule
